[rtl/iircr_pkg.sv]
// Shared types and constants for the third-order IIR current regulator.
`default_nettype none

package iircr_pkg;

  // Fixed datapath widths
  localparam int COEF_W  = 24;  // signed Q3.20 coefficient
  localparam int ERR_W   = 18;  // signed error sample
  localparam int OUT_W   = 16;  // saturated controller output
  localparam int DUTY_W  = 8;   // duty value
  localparam int PE_W    = COEF_W + ERR_W;  // coefficient times error
  localparam int PY_W    = COEF_W + OUT_W;  // coefficient times output
  localparam int ACC_W   = 46;  // sum of seven products, no overflow
  localparam int DATA_W  = 32;  // APB data width
  localparam int ADDR_W  = 5;   // byte address of eight 32-bit registers
  localparam int IDX_W   = 3;   // register index width

  // Register index map
  typedef enum logic [IDX_W-1:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_B3    = 3'd3,
    REG_A1    = 3'd4,
    REG_A2    = 3'd5,
    REG_A3    = 3'd6,
    REG_LIMIT = 3'd7
  } reg_idx_t;

  // Register reset values
  localparam logic signed [COEF_W-1:0] B0_RST = 24'sd25449;
  localparam logic signed [COEF_W-1:0] B1_RST = -24'sd24222;
  localparam logic signed [COEF_W-1:0] B2_RST = -24'sd25449;
  localparam logic signed [COEF_W-1:0] B3_RST = 24'sd24222;
  localparam logic signed [COEF_W-1:0] A1_RST = -24'sd3144679;
  localparam logic signed [COEF_W-1:0] A2_RST = 24'sd3143631;
  localparam logic signed [COEF_W-1:0] A3_RST = -24'sd1047527;
  localparam logic [DUTY_W-1:0]        LIMIT_RST = 8'd100;

  // Configuration register set
  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] b3;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] a3;
    logic [DUTY_W-1:0]        limit;
  } coef_t;

  // Filter history: errors and outputs one, two and three ticks old
  typedef struct packed {
    logic signed [ERR_W-1:0] e1;
    logic signed [ERR_W-1:0] e2;
    logic signed [ERR_W-1:0] e3;
    logic signed [OUT_W-1:0] y1;
    logic signed [OUT_W-1:0] y2;
    logic signed [OUT_W-1:0] y3;
  } hist_t;

  // Datapath result for one sample
  typedef struct packed {
    logic signed [ERR_W-1:0] e0;
    logic signed [OUT_W-1:0] y0;
    logic [DUTY_W-1:0]       duty_a;
    logic [DUTY_W-1:0]       duty_b;
    logic                    clamped;
  } step_t;

endpackage

`default_nettype wire

[rtl/iircr_datapath.sv]
// Single-pass IIR recursion, output saturation and duty clamp for one sample.
`default_nettype none

module iircr_datapath #(
  parameter int COEF_FRAC_BITS = 20,
  parameter int SAMPLE_BITS    = 10
) (
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire iircr_pkg::coef_t       coef,
  input  wire iircr_pkg::hist_t       hist,
  output iircr_pkg::step_t            res
);

  localparam logic signed [iircr_pkg::ACC_W-1:0] Y_MAX =
    iircr_pkg::ACC_W'(32767);
  localparam logic signed [iircr_pkg::ACC_W-1:0] Y_MIN =
    -(iircr_pkg::ACC_W'(32768));

  logic signed [iircr_pkg::ERR_W-1:0] samp_x;
  logic signed [iircr_pkg::ERR_W-1:0] y1_x;
  logic signed [iircr_pkg::ERR_W-1:0] e0;
  logic signed [iircr_pkg::PE_W-1:0]  pb0, pb1, pb2, pb3;
  logic signed [iircr_pkg::PY_W-1:0]  pa1, pa2, pa3;
  logic signed [iircr_pkg::ACC_W-1:0] acc;
  logic signed [iircr_pkg::ACC_W-1:0] acc_sh;
  logic signed [iircr_pkg::OUT_W-1:0] y0;
  logic [iircr_pkg::DUTY_W-1:0]       da;
  logic                               flag;

  // Error against the previous output
  assign samp_x = $signed({{(iircr_pkg::ERR_W-SAMPLE_BITS){1'b0}}, sample});
  assign y1_x   = iircr_pkg::ERR_W'(hist.y1);
  assign e0     = samp_x - y1_x;

  // Seven parallel products
  assign pb0 = iircr_pkg::PE_W'(coef.b0) * iircr_pkg::PE_W'(e0);
  assign pb1 = iircr_pkg::PE_W'(coef.b1) * iircr_pkg::PE_W'(hist.e1);
  assign pb2 = iircr_pkg::PE_W'(coef.b2) * iircr_pkg::PE_W'(hist.e2);
  assign pb3 = iircr_pkg::PE_W'(coef.b3) * iircr_pkg::PE_W'(hist.e3);
  assign pa1 = iircr_pkg::PY_W'(coef.a1) * iircr_pkg::PY_W'(hist.y1);
  assign pa2 = iircr_pkg::PY_W'(coef.a2) * iircr_pkg::PY_W'(hist.y2);
  assign pa3 = iircr_pkg::PY_W'(coef.a3) * iircr_pkg::PY_W'(hist.y3);

  // Feedforward minus feedback, then floor shift by the fraction bits
  assign acc = iircr_pkg::ACC_W'(pb0) + iircr_pkg::ACC_W'(pb1)
             + iircr_pkg::ACC_W'(pb2) + iircr_pkg::ACC_W'(pb3)
             - iircr_pkg::ACC_W'(pa1) - iircr_pkg::ACC_W'(pa2)
             - iircr_pkg::ACC_W'(pa3);
  assign acc_sh = acc >>> COEF_FRAC_BITS;

  // Saturate to signed 16 bits
  always_comb begin
    if (acc_sh > Y_MAX) begin
      y0 = 16'sh7fff;
    end else if (acc_sh < Y_MIN) begin
      y0 = -16'sh8000;
    end else begin
      y0 = acc_sh[iircr_pkg::OUT_W-1:0];
    end
  end

  // Clamp to 0..limit
  always_comb begin
    if (y0[iircr_pkg::OUT_W-1]) begin
      da   = '0;
      flag = 1'b1;
    end else if (y0[iircr_pkg::OUT_W-2:0] >
                 {{(iircr_pkg::OUT_W-1-iircr_pkg::DUTY_W){1'b0}}, coef.limit}) begin
      da   = coef.limit;
      flag = 1'b1;
    end else begin
      da   = y0[iircr_pkg::DUTY_W-1:0];
      flag = 1'b0;
    end
  end

  assign res.e0      = e0;
  assign res.y0      = y0;
  assign res.duty_a  = da;
  assign res.duty_b  = coef.limit - da;
  assign res.clamped = flag;

endmodule

`default_nettype wire

[rtl/iir_current_regulator.sv]
// Top level of the third-order direct form I current regulator.
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       request    in_valid / in_stall  in_current_sample
// out_      result     out_valid/out_stall  out_duty_a, out_duty_b, out_clamped
// cfg (APB) write/read psel/penable/pready  paddr, pwdata, prdata
//
// One sample per cycle sustained while the output is not stalled; each request
// passes from the input register through the seven multipliers and the sum into
// the result register, and the history feedback closes in that same pass.
// Reset clears history and valid flags and loads the default coefficients.
// A stalled output holds its result while one further request is still taken.

module iir_current_regulator #(
  parameter int COEF_FRAC_BITS = 20,
  parameter int SAMPLE_BITS    = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [SAMPLE_BITS-1:0]         in_current_sample,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [iircr_pkg::DUTY_W-1:0]        out_duty_a,
  output logic [iircr_pkg::DUTY_W-1:0]        out_duty_b,
  output logic                                out_clamped,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [iircr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [iircr_pkg::DATA_W-1:0]   pwdata,
  output logic [iircr_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);

  iircr_pkg::coef_t    coef_r;
  iircr_pkg::hist_t    hist_r;
  iircr_pkg::step_t    step;
  iircr_pkg::reg_idx_t idx;

  logic                         s1_valid_r;
  logic [SAMPLE_BITS-1:0]       s1_sample_r;
  logic                         out_valid_r;
  logic [iircr_pkg::DUTY_W-1:0] duty_a_r, duty_b_r;
  logic                         clamped_r;
  logic                         advance;
  logic                         cfg_wr;

  // Register file
  assign pready = 1'b1;
  assign idx    = iircr_pkg::reg_idx_t'(paddr[iircr_pkg::ADDR_W-1:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0    <= iircr_pkg::B0_RST;
      coef_r.b1    <= iircr_pkg::B1_RST;
      coef_r.b2    <= iircr_pkg::B2_RST;
      coef_r.b3    <= iircr_pkg::B3_RST;
      coef_r.a1    <= iircr_pkg::A1_RST;
      coef_r.a2    <= iircr_pkg::A2_RST;
      coef_r.a3    <= iircr_pkg::A3_RST;
      coef_r.limit <= iircr_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (idx)
        iircr_pkg::REG_B0:    coef_r.b0    <= pwdata[iircr_pkg::COEF_W-1:0];
        iircr_pkg::REG_B1:    coef_r.b1    <= pwdata[iircr_pkg::COEF_W-1:0];
        iircr_pkg::REG_B2:    coef_r.b2    <= pwdata[iircr_pkg::COEF_W-1:0];
        iircr_pkg::REG_B3:    coef_r.b3    <= pwdata[iircr_pkg::COEF_W-1:0];
        iircr_pkg::REG_A1:    coef_r.a1    <= pwdata[iircr_pkg::COEF_W-1:0];
        iircr_pkg::REG_A2:    coef_r.a2    <= pwdata[iircr_pkg::COEF_W-1:0];
        iircr_pkg::REG_A3:    coef_r.a3    <= pwdata[iircr_pkg::COEF_W-1:0];
        iircr_pkg::REG_LIMIT: coef_r.limit <= pwdata[iircr_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, coefficients sign-extended
  always_comb begin
    unique case (idx)
      iircr_pkg::REG_B0:    prdata = iircr_pkg::DATA_W'(coef_r.b0);
      iircr_pkg::REG_B1:    prdata = iircr_pkg::DATA_W'(coef_r.b1);
      iircr_pkg::REG_B2:    prdata = iircr_pkg::DATA_W'(coef_r.b2);
      iircr_pkg::REG_B3:    prdata = iircr_pkg::DATA_W'(coef_r.b3);
      iircr_pkg::REG_A1:    prdata = iircr_pkg::DATA_W'(coef_r.a1);
      iircr_pkg::REG_A2:    prdata = iircr_pkg::DATA_W'(coef_r.a2);
      iircr_pkg::REG_A3:    prdata = iircr_pkg::DATA_W'(coef_r.a3);
      iircr_pkg::REG_LIMIT: prdata = {{(iircr_pkg::DATA_W-iircr_pkg::DUTY_W){1'b0}},
                                      coef_r.limit};
      default:              prdata = '0;
    endcase
  end

  // Flow control: input register moves on when the result register is free
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample_r <= in_current_sample;
    end
  end

  // Recursion datapath
  iircr_datapath #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_datapath (
    .sample (s1_sample_r),
    .coef   (coef_r),
    .hist   (hist_r),
    .res    (step)
  );

  // History shift on each processed sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (advance) begin
      hist_r.e3 <= hist_r.e2;
      hist_r.e2 <= hist_r.e1;
      hist_r.e1 <= step.e0;
      hist_r.y3 <= hist_r.y2;
      hist_r.y2 <= hist_r.y1;
      hist_r.y1 <= step.y0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      duty_a_r  <= step.duty_a;
      duty_b_r  <= step.duty_b;
      clamped_r <= step.clamped;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_duty_a  = duty_a_r;
  assign out_duty_b  = duty_b_r;
  assign out_clamped = clamped_r;

endmodule

`default_nettype wire

[tb/tb_iir_current_regulator.sv]
// Self-checking testbench for the third-order IIR current regulator.
module tb_iir_current_regulator;
  timeunit 1ns;
  timeprecision 1ps;

  import iircr_pkg::*;

  localparam int FRAC           = 20;
  localparam int SAMPLE_W       = 10;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int RANDOM_ITEMS   = 450;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int GENTLE_RANGE   = 1 << 18;
  localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sd1048576;  // 1.0 in Q3.20
  localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum int {SET_FULL, SET_GENTLE, SET_DEFAULT} setting_kind_t;

  // One duty request result
  typedef struct {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic              clamped;
  } duty_pair_t;

  // DUT connections; every input known from time zero
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_current_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DUTY_W-1:0]   out_duty_a;
  logic [DUTY_W-1:0]   out_duty_b;
  logic                out_clamped;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  iir_current_regulator #(
    .COEF_FRAC_BITS(FRAC),
    .SAMPLE_BITS   (SAMPLE_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_current_sample(in_current_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty_a       (out_duty_a),
    .out_duty_b       (out_duty_b),
    .out_clamped      (out_clamped),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Regulator model state
  coef_t                   model_cfg;
  logic signed [ERR_W-1:0] err_hist [3];
  logic signed [OUT_W-1:0] out_hist [3];
  duty_pair_t              duty_expected [$];

  int fail_count      = 0;
  int samples_sent    = 0;
  int results_checked = 0;
  int clamp_count     = 0;
  int settings_loaded = 0;
  int burst_left      = 0;
  int quiet_cycles    = 0;

  function automatic coef_t reset_setting();
    coef_t c;
    c.b0 = B0_RST; c.b1 = B1_RST; c.b2 = B2_RST; c.b3 = B3_RST;
    c.a1 = A1_RST; c.a2 = A2_RST; c.a3 = A3_RST;
    c.limit = LIMIT_RST;
    return c;
  endfunction

  function automatic void model_reset();
    model_cfg = reset_setting();
    for (int i = 0; i < 3; i++) begin
      err_hist[i] = '0;
      out_hist[i] = '0;
    end
  endfunction

  // Error, DF-I recursion, floor shift, saturation, duty clamp
  function automatic duty_pair_t regulate(input logic [SAMPLE_W-1:0] sample);
    longint     e0;
    longint     acc;
    longint     y;
    longint     lim;
    longint     da;
    duty_pair_t r;
    e0  = longint'(sample) - longint'(out_hist[0]);
    acc = longint'($signed(model_cfg.b0)) * e0
        + longint'($signed(model_cfg.b1)) * longint'(err_hist[0])
        + longint'($signed(model_cfg.b2)) * longint'(err_hist[1])
        + longint'($signed(model_cfg.b3)) * longint'(err_hist[2])
        - longint'($signed(model_cfg.a1)) * longint'(out_hist[0])
        - longint'($signed(model_cfg.a2)) * longint'(out_hist[1])
        - longint'($signed(model_cfg.a3)) * longint'(out_hist[2]);
    y = acc >>> FRAC;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    err_hist[2] = err_hist[1];
    err_hist[1] = err_hist[0];
    err_hist[0] = e0[ERR_W-1:0];
    out_hist[2] = out_hist[1];
    out_hist[1] = out_hist[0];
    out_hist[0] = y[OUT_W-1:0];
    lim = longint'(model_cfg.limit);
    da  = y;
    r.clamped = 1'b0;
    if (da < 0) begin
      da = 0;
      r.clamped = 1'b1;
    end else if (da > lim) begin
      da = lim;
      r.clamped = 1'b1;
    end
    r.duty_a = da[DUTY_W-1:0];
    r.duty_b = 8'(lim - da);
    return r;
  endfunction

  // Bus word for one register, coefficients sign-extended
  function automatic logic [DATA_W-1:0] reg_word(coef_t c, reg_idx_t idx);
    case (idx)
      REG_B0:  return {{(DATA_W-COEF_W){c.b0[COEF_W-1]}}, c.b0};
      REG_B1:  return {{(DATA_W-COEF_W){c.b1[COEF_W-1]}}, c.b1};
      REG_B2:  return {{(DATA_W-COEF_W){c.b2[COEF_W-1]}}, c.b2};
      REG_B3:  return {{(DATA_W-COEF_W){c.b3[COEF_W-1]}}, c.b3};
      REG_A1:  return {{(DATA_W-COEF_W){c.a1[COEF_W-1]}}, c.a1};
      REG_A2:  return {{(DATA_W-COEF_W){c.a2[COEF_W-1]}}, c.a2};
      REG_A3:  return {{(DATA_W-COEF_W){c.a3[COEF_W-1]}}, c.a3};
      default: return {{(DATA_W-DUTY_W){1'b0}}, c.limit};
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef(setting_kind_t kind);
    logic [31:0] bits;
    int          v;
    bits = $urandom();
    v    = int'($urandom_range(0, 2 * GENTLE_RANGE)) - GENTLE_RANGE;
    if (kind == SET_FULL) return bits[COEF_W-1:0];
    return v[COEF_W-1:0];
  endfunction

  function automatic coef_t random_setting();
    setting_kind_t kind;
    coef_t         c;
    kind = setting_kind_t'($urandom_range(0, 2));
    if (kind == SET_DEFAULT) begin
      c = reset_setting();
    end else begin
      c.b0 = rand_coef(kind); c.b1 = rand_coef(kind);
      c.b2 = rand_coef(kind); c.b3 = rand_coef(kind);
      c.a1 = rand_coef(kind); c.a2 = rand_coef(kind);
      c.a3 = rand_coef(kind);
    end
    case ($urandom_range(0, 3))
      0:       c.limit = 8'd1;
      1:       c.limit = 8'd255;
      default: c.limit = 8'($urandom_range(1, 255));
    endcase
    return c;
  endfunction

  function automatic coef_t uniform_setting(logic signed [COEF_W-1:0] v,
                                            logic [DUTY_W-1:0] lim);
    coef_t c;
    c.b0 = v; c.b1 = v; c.b2 = v; c.b3 = v;
    c.a1 = v; c.a2 = v; c.a3 = v;
    c.limit = lim;
    return c;
  endfunction

  // APB access: setup cycle, then access cycle until pready
  task automatic apb_access(input reg_idx_t idx, input logic wr,
                            input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_reg(input reg_idx_t idx, input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] mask;
    mask = (idx == REG_LIMIT) ? DATA_W'({DUTY_W{1'b1}}) : DATA_W'({COEF_W{1'b1}});
    apb_access(idx, 1'b0, '0, rd);
    if ((rd & mask) !== (want & mask)) begin
      $error("register %s readback: expected 0x%0h, got 0x%0h",
             idx.name(), want & mask, rd & mask);
      fail_count++;
    end
  endtask

  // Write every register with read-back, then adopt the setting
  task automatic load_setting(input coef_t c);
    reg_idx_t          idx;
    logic [DATA_W-1:0] rd;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      apb_access(idx, 1'b1, reg_word(c, idx), rd);
      check_reg(idx, reg_word(c, idx));
    end
    model_cfg = c;
    settings_loaded++;
  endtask

  // Send one request; bursts of random length with random gaps between them
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid          = 1'b1;
    in_current_sample = s;
    do @(posedge clk); while (in_stall);
    duty_expected.push_back(regulate(s));
    samples_sent++;
  endtask

  // Stop sending and let all outstanding requests drain
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (duty_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SAMPLE_W'(SAMPLE_MAX);
      default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    endcase
  endfunction

  // Reset values read back, then a few samples through the default loop
  task automatic test_reset_defaults();
    coef_t    c;
    reg_idx_t idx;
    c = reset_setting();
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      check_reg(idx, reg_word(c, idx));
    end
    send_sample('0);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample('0);
    drain();
  endtask

  // Unity b0: output follows the error, hits both clamp sides
  task automatic test_unity_gain();
    coef_t c;
    c       = uniform_setting('0, 8'd255);
    c.b0    = COEF_ONE;
    load_setting(c);
    send_sample('0);
    send_sample(SAMPLE_W'(255));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(100));
    send_sample(SAMPLE_W'(1));
    drain();
  endtask

  // Zero duty limit: both duties zero, flag whenever output is nonzero
  task automatic test_zero_limit();
    coef_t c;
    c    = uniform_setting('0, 8'd0);
    c.b0 = COEF_ONE;
    load_setting(c);
    send_sample('0);
    send_sample(SAMPLE_W'(5));
    send_sample('0);
    drain();
  endtask

  // Coefficient extremes drive the output into saturation both ways
  task automatic test_coef_extremes();
    load_setting(uniform_setting(COEF_MAX, 8'd255));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample('0);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    drain();
    load_setting(uniform_setting(COEF_MIN, 8'd255));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample('0);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    drain();
  endtask

  // Random samples in phases, a new random setting between phases
  task automatic test_random_phases();
    coef_t c;
    int    phase;
    int    phase_len;
    int    sent;
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      c = random_setting();
      if (phase == 0) c.limit = 8'd1;
      if (phase == 1) c.limit = 8'd255;
      load_setting(c);
      phase_len = $urandom_range(30, 70);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      for (int i = 0; i < phase_len; i++) send_sample(random_sample());
      sent += phase_len;
      drain();
      phase++;
    end
  endtask

  // Receiver stall pattern, switching mode every so often
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          stall_tick = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 120);
    end
    mode_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
      default:     out_stall = ((stall_tick % 7) < 3);
    endcase
  end

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    duty_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (duty_expected.size() == 0) begin
        $error("result with no request outstanding: duty_a %0d duty_b %0d clamped %0b",
               out_duty_a, out_duty_b, out_clamped);
        fail_count++;
      end else begin
        want = duty_expected.pop_front();
        results_checked++;
        if (want.clamped) clamp_count++;
        if (out_duty_a !== want.duty_a) begin
          $error("duty_a mismatch: expected %0d, got %0d", want.duty_a, out_duty_a);
          fail_count++;
        end
        if (out_duty_b !== want.duty_b) begin
          $error("duty_b mismatch: expected %0d, got %0d", want.duty_b, out_duty_b);
          fail_count++;
        end
        if (out_clamped !== want.clamped) begin
          $error("clamped mismatch: expected %0b, got %0b", want.clamped, out_clamped);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_iir_current_regulator NOT OK");
      $finish;
    end
  end

  // Test sequence
  initial begin
    model_reset();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_unity_gain();
    test_zero_limit();
    test_coef_extremes();
    test_random_phases();

    if (duty_expected.size() != 0) begin
      $error("%0d expected results never arrived", duty_expected.size());
      fail_count++;
    end
    $display("Sent %0d current samples under %0d register settings.",
             samples_sent, settings_loaded);
    $display("Checked %0d duty results, %0d of them clamped.", results_checked, clamp_count);
    if (fail_count == 0)
      $display("tb_iir_current_regulator OK");
    else
      $display("tb_iir_current_regulator NOT OK");
    $finish;
  end

endmodule
